// ===== hw/rtl/y86fd_pkg.sv =====
// y86fd_pkg: shared types and constants for the y86 fetch/decode block
// holds status codes, instruction codes and the decoded result struct
// no dependencies
package y86fd_pkg;

	// fetch status codes
	typedef enum logic [1:0] {
		ST_AOK = 2'd0,
		ST_HLT = 2'd1,
		ST_ADR = 2'd2,
		ST_INS = 2'd3
	} fd_status_t;

	// instruction codes
	localparam logic [3:0] I_HALT   = 4'h0;
	localparam logic [3:0] I_NOP    = 4'h1;
	localparam logic [3:0] I_RRMOVL = 4'h2;
	localparam logic [3:0] I_IRMOVL = 4'h3;
	localparam logic [3:0] I_RMMOVL = 4'h4;
	localparam logic [3:0] I_MRMOVL = 4'h5;
	localparam logic [3:0] I_OPL    = 4'h6;
	localparam logic [3:0] I_JXX    = 4'h7;
	localparam logic [3:0] I_CALL   = 4'h8;
	localparam logic [3:0] I_RET    = 4'h9;
	localparam logic [3:0] I_PUSHL  = 4'hA;
	localparam logic [3:0] I_POPL   = 4'hB;

	// highest function codes that are defined
	localparam logic [3:0] FN_OPL_MAX = 4'd3;
	localparam logic [3:0] FN_JXX_MAX = 4'd6;

	// register id that means no register
	localparam logic [3:0] REG_NONE = 4'hF;

	// mem_limit after reset
	localparam logic [31:0] MEM_LIMIT_RST = 32'h0000_FFFF;

	// stream widths
	localparam int unsigned IN_W  = 80;
	localparam int unsigned OUT_W = 120;

	// decoded instruction
	typedef struct packed {
		logic        has_const;
		logic        has_regids;
		logic [31:0] predicted_pc;
		logic [31:0] next_pc;
		logic [31:0] const_val;
		logic [3:0]  reg_b;
		logic [3:0]  reg_a;
		logic [3:0]  ifun_out;
		logic [3:0]  icode_out;
		fd_status_t  status;
	} fd_result_t;

endpackage

// ===== hw/rtl/y86fd_decode.sv =====
// y86fd_decode: combinational fetch decode of one instruction
// address check, icode/ifun split, length, register byte, constant, next pc
// depends on y86fd_pkg
module y86fd_decode
	import y86fd_pkg::*;
(
	input  logic [31:0] fetch_pc,
	input  logic [47:0] instr_bytes,
	input  logic [31:0] mem_limit,
	output fd_result_t  res
);

	logic [3:0]  icode;
	logic [3:0]  ifun;
	logic        valid;
	logic        regs;
	logic        cons;
	logic [2:0]  len;
	logic [31:0] valc;
	logic [31:0] valp;

	// split first byte and check codes
	assign icode = instr_bytes[7:4];
	assign ifun  = instr_bytes[3:0];

	always_comb begin
		valid = (icode <= I_POPL);
		if (icode == I_OPL && ifun > FN_OPL_MAX) valid = 1'b0;
		if ((icode == I_JXX || icode == I_RRMOVL) && ifun > FN_JXX_MAX) valid = 1'b0;
	end

	// which optional parts follow the first byte
	assign regs = (icode >= I_RRMOVL && icode <= I_OPL) || icode == I_PUSHL ||
		icode == I_POPL;
	assign cons = icode >= I_IRMOVL && icode <= I_CALL && icode != I_OPL;

	// constant position depends on the register byte
	always_comb begin
		if (!cons) begin
			valc = '0;
		end else if (regs) begin
			valc = instr_bytes[47:16];
		end else begin
			valc = instr_bytes[39:8];
		end
	end

	assign len  = 3'd1 + {2'b00, regs} + (cons ? 3'd4 : 3'd0);
	assign valp = fetch_pc + {29'd0, len};

	// result, with address error override
	always_comb begin
		if (fetch_pc > mem_limit) begin
			res.status       = ST_ADR;
			res.icode_out    = I_NOP;
			res.ifun_out     = '0;
			res.reg_a        = REG_NONE;
			res.reg_b        = REG_NONE;
			res.const_val    = '0;
			res.next_pc      = fetch_pc + 32'd1;
			res.predicted_pc = fetch_pc + 32'd1;
			res.has_regids   = 1'b0;
			res.has_const    = 1'b0;
		end else begin
			if (!valid) res.status = ST_INS;
			else if (icode == I_HALT) res.status = ST_HLT;
			else res.status = ST_AOK;
			res.icode_out    = icode;
			res.ifun_out     = ifun;
			res.reg_a        = regs ? instr_bytes[15:12] : REG_NONE;
			res.reg_b        = regs ? instr_bytes[11:8] : REG_NONE;
			res.const_val    = valc;
			res.next_pc      = valp;
			res.predicted_pc = (icode == I_JXX || icode == I_CALL) ? valc : valp;
			res.has_regids   = regs;
			res.has_const    = cons;
		end
	end

endmodule

// ===== hw/rtl/y86_fetch_decode.sv =====
// y86_fetch_decode: top level of the y86 fetch/decode block
// input register, decode logic, result register and the mem_limit register
// depends on y86fd_pkg and y86fd_decode
//
// Each beat on s_* carries one fetch pc and the six instruction bytes at it;
// one decoded beat per input beat leaves on m_* in order, after the input register
// and the result register. The block takes a new beat every cycle: the two registers
// form a two-stage pipeline that advances whenever the result is taken or empty,
// so throughput is one instruction per clock with m_tready held high. The user
// writes mem_limit through cfg_we/cfg_wdata while the block is idle (not enforced
// by the block). It resets to 65535; a pc above it decodes as an address error nop.
module y86_fetch_decode
	import y86fd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	// fetch_pc [31:0], instr_bytes [79:32]
	input  logic [IN_W-1:0]    s_tdata,
	// output stream
	output logic               m_tvalid,
	input  logic               m_tready,
	// status [1:0], icode_out [5:2], ifun_out [9:6], reg_a [13:10], reg_b [17:14],
	// const_val [49:18], next_pc [81:50], predicted_pc [113:82], has_regids [114],
	// has_const [115], zero pad [119:116]
	output logic [OUT_W-1:0]   m_tdata
);

	logic [31:0] mem_limit_q;
	logic        valid_s1;
	logic [31:0] pc_s1;
	logic [47:0] bytes_s1;
	logic        valid_s2;
	fd_result_t  res;
	fd_result_t  res_s2;
	logic        adv_s2;
	logic        adv_s1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_limit_q <= MEM_LIMIT_RST;
		end else if (cfg_we) begin
			mem_limit_q <= cfg_wdata;
		end
	end

	// pipeline flow control
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = adv_s2;
	assign s_tready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pc_s1    <= s_tdata[31:0];
			bytes_s1 <= s_tdata[79:32];
		end
	end

	// decode
	y86fd_decode u_decode (
		.fetch_pc    (pc_s1),
		.instr_bytes (bytes_s1),
		.mem_limit   (mem_limit_q),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	// output beat
	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2};

	// checks on the decoded beat
	a_adr_nop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.status == ST_ADR |->
		res_s2.icode_out == I_NOP && !res_s2.has_regids && !res_s2.has_const)
		else $error("address error beat is not a plain nop");

	a_no_const: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_s2.has_const |-> res_s2.const_val == 32'd0)
		else $error("const_val nonzero without a constant");

	a_no_regs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_s2.has_regids |->
		res_s2.reg_a == REG_NONE && res_s2.reg_b == REG_NONE)
		else $error("register ids set without a register byte");

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted beat lost at input register");

	a_move_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> m_tvalid)
		else $error("decoded beat lost at result register");

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for the y86 fetch/decode block (y86_fetch_decode)
// feeds fetch beats with random idling and backpressure, predicts each decoded beat
// depends on y86fd_pkg and the y86_fetch_decode rtl
module tb;
	import y86fd_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [31:0]       cfg_wdata = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	// fetch_pc [31:0], instr_bytes [79:32]
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// status, icode_out, ifun_out, reg_a, reg_b, const_val, next_pc, predicted_pc,
	// has_regids, has_const, zero pad (lowest bit up)
	logic [OUT_W-1:0]  m_tdata;

	// bench copy of the limit register
	logic [31:0]       addr_limit = MEM_LIMIT_RST;
	fd_result_t        decoded_q[$];
	bit                idle_in = 1'b0;
	bit                idle_out = 1'b0;
	int                hold_off_cycles = 0;
	int                n_sent = 0;
	int                n_checked = 0;
	int                n_errors = 0;
	int                n_adr = 0;
	int                n_ins = 0;
	int                n_hlt = 0;

	y86_fetch_decode dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// clock, period 10
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected decode of one fetch under the current limit
	function automatic fd_result_t decode_fetch(logic [31:0] pc, logic [47:0] bytes);
		fd_result_t r;
		logic [3:0] ic;
		logic [3:0] fn;
		logic       ok;
		logic [31:0] len;
		r = '0;
		if (pc > addr_limit) begin
			r.status = ST_ADR;
			r.icode_out = I_NOP;
			r.reg_a = REG_NONE;
			r.reg_b = REG_NONE;
			r.next_pc = pc + 32'd1;
			r.predicted_pc = r.next_pc;
			return r;
		end
		ic = bytes[7:4];
		fn = bytes[3:0];
		ok = (ic <= I_POPL);
		if (ic == I_OPL && fn > FN_OPL_MAX)
			ok = 1'b0;
		if ((ic == I_JXX || ic == I_RRMOVL) && fn > FN_JXX_MAX)
			ok = 1'b0;
		if (!ok)
			r.status = ST_INS;
		else if (ic == I_HALT)
			r.status = ST_HLT;
		else
			r.status = ST_AOK;
		r.icode_out = ic;
		r.ifun_out = fn;
		r.has_regids = (ic >= I_RRMOVL && ic <= I_OPL) || ic == I_PUSHL || ic == I_POPL;
		r.has_const = ic >= I_IRMOVL && ic <= I_CALL && ic != I_OPL;
		// register byte shifts the constant up by one byte
		if (r.has_regids) begin
			r.reg_a = bytes[15:12];
			r.reg_b = bytes[11:8];
			r.const_val = r.has_const ? bytes[47:16] : 32'd0;
			len = r.has_const ? 32'd6 : 32'd2;
		end else begin
			r.reg_a = REG_NONE;
			r.reg_b = REG_NONE;
			r.const_val = r.has_const ? bytes[39:8] : 32'd0;
			len = r.has_const ? 32'd5 : 32'd1;
		end
		r.next_pc = pc + len;
		r.predicted_pc = (ic == I_JXX || ic == I_CALL) ? r.const_val : r.next_pc;
		return r;
	endfunction

	// mostly well-formed opcodes with random operand bytes
	function automatic logic [47:0] make_instr_bytes();
		logic [63:0] raw;
		logic [3:0]  ic;
		logic [3:0]  fn;
		raw = {$urandom, $urandom};
		ic = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
		case (ic)
			I_OPL:            fn = 4'($urandom_range(0, FN_OPL_MAX));
			I_JXX, I_RRMOVL:  fn = 4'($urandom_range(0, FN_JXX_MAX));
			default:          fn = 4'd0;
		endcase
		// some function nibbles anywhere, valid or not
		if ($urandom_range(0, 6) == 0)
			fn = 4'($urandom_range(0, 15));
		raw[7:0] = {ic, fn};
		return raw[47:0];
	endfunction

	// pc spread around the limit and the top of the address space
	function automatic logic [31:0] pick_pc();
		case ($urandom_range(0, 9))
			6:       return addr_limit;
			7:       return addr_limit + 32'd1;
			8:       return $urandom;
			9:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
			default: return $urandom_range(0, addr_limit);
		endcase
	endfunction

	// one fetch beat: random gap, then hold valid until accepted
	task automatic send_fetch(input logic [31:0] pc, input logic [47:0] bytes);
		int         gap;
		fd_result_t exp_r;
		gap = idle_in ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {bytes, pc};
		do @(posedge clk); while (!s_tready);
		exp_r = decode_fetch(pc, bytes);
		decoded_q.push_back(exp_r);
		n_sent++;
		if (exp_r.status == ST_ADR) n_adr++;
		if (exp_r.status == ST_INS) n_ins++;
		if (exp_r.status == ST_HLT) n_hlt++;
	endtask

	// stop offering and wait for every decoded beat
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_mem_limit(input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		addr_limit = v;
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
		end
	endtask

	// result side: random stall per beat, optional long hold-off, then compare
	initial begin
		int         stall;
		fd_result_t exp_r;
		fd_result_t got;
		forever begin
			stall = idle_out ? $urandom_range(0, 9) : 0;
			stall += hold_off_cycles;
			hold_off_cycles = 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = fd_result_t'(m_tdata[115:0]);
			if (decoded_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
			end else begin
				exp_r = decoded_q.pop_front();
				n_checked++;
				check_field("status", 32'(exp_r.status), 32'(got.status));
				check_field("icode_out", 32'(exp_r.icode_out), 32'(got.icode_out));
				check_field("ifun_out", 32'(exp_r.ifun_out), 32'(got.ifun_out));
				check_field("reg_a", 32'(exp_r.reg_a), 32'(got.reg_a));
				check_field("reg_b", 32'(exp_r.reg_b), 32'(got.reg_b));
				check_field("const_val", exp_r.const_val, got.const_val);
				check_field("next_pc", exp_r.next_pc, got.next_pc);
				check_field("predicted_pc", exp_r.predicted_pc, got.predicted_pc);
				check_field("has_regids", 32'(exp_r.has_regids), 32'(got.has_regids));
				check_field("has_const", 32'(exp_r.has_const), 32'(got.has_const));
			end
		end
	end

	// every opcode, bad function codes and the address limit edges
	task automatic test_directed();
		logic [63:0] raw;
		send_fetch(32'd0, 48'd0);
		for (int ic = 1; ic < 16; ic++) begin
			raw = {$urandom, $urandom};
			raw[7:0] = {4'(ic), 4'd0};
			send_fetch($urandom_range(0, addr_limit), raw[47:0]);
		end
		raw = {$urandom, $urandom};
		send_fetch(32'd100, {raw[47:8], I_OPL, FN_OPL_MAX});
		send_fetch(32'd101, {raw[47:8], I_OPL, 4'd4});
		send_fetch(32'd102, {raw[47:8], I_JXX, FN_JXX_MAX});
		send_fetch(32'd103, {raw[47:8], I_JXX, 4'd7});
		send_fetch(32'd104, {raw[47:8], I_RRMOVL, 4'd7});
		send_fetch(32'd105, {raw[47:8], I_CALL, 4'd15});
		send_fetch(addr_limit, 48'hFFFF_FFFF_FFFF);
		send_fetch(addr_limit + 32'd1, 48'h0000_0000_0070);
		send_fetch(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		wait_results_done();
	endtask

	// several limits, the extremes among them
	task automatic test_mem_limit();
		logic [31:0] limits[4];
		limits[0] = 32'd0;
		limits[1] = 32'hFFFF_FFFF;
		limits[2] = 32'h8000_0000;
		limits[3] = $urandom;
		idle_in = 1'b1;
		idle_out = 1'b1;
		foreach (limits[i]) begin
			write_mem_limit(limits[i]);
			repeat (20) send_fetch(pick_pc(), make_instr_bytes());
			wait_results_done();
		end
		write_mem_limit(MEM_LIMIT_RST);
	endtask

	// receiver holds off while beats keep coming, then the sender waits for all
	task automatic test_backpressure();
		idle_in = 1'b0;
		idle_out = 1'b0;
		hold_off_cycles = 300;
		repeat (40) send_fetch(pick_pc(), make_instr_bytes());
		wait_results_done();
		repeat (20) send_fetch(pick_pc(), make_instr_bytes());
		wait_results_done();
	endtask

	// random blocks, each with its own idling mode and limit
	task automatic test_random();
		int mode;
		for (int blk = 0; blk < 6; blk++) begin
			mode = $urandom_range(0, 3);
			idle_in = mode[0];
			idle_out = mode[1];
			case (blk)
				0:       write_mem_limit(MEM_LIMIT_RST);
				1:       write_mem_limit(32'hFFFF_FFFF);
				2:       write_mem_limit(32'd0);
				default: write_mem_limit($urandom);
			endcase
			repeat (300) send_fetch(pick_pc(), make_instr_bytes());
			wait_results_done();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mem_limit();
		test_backpressure();
		test_random();
		wait_results_done();
		repeat (20) @(posedge clk);
		if (decoded_q.size() != 0)
			n_errors++;
		$display("covered %0d fetches, %0d decoded beats checked", n_sent, n_checked);
		$display("  %0d address errors, %0d invalid, %0d halts, limits from zero to the top",
			n_adr, n_ins, n_hlt);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("timeout with %0d results outstanding", decoded_q.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
